// ----- rtl/core/bts_pkg.sv -----
// Package for the button toggled stepper sequencer.
// Holds the request and result payload types, mode codes and coil table.
// No dependencies.
package bts_pkg;

    typedef struct packed {
        logic fwd_button_raw;
        logic rev_button_raw;
    } in_item_t;

    typedef struct packed {
        logic [3:0] coil_pattern;
        logic [1:0] motor_mode;
        logic       step_taken;
        logic       fwd_button_level;
        logic       rev_button_level;
    } out_item_t;

    // Status of one debounced button after the current tick.
    typedef struct packed {
        logic level;
        logic rise;
    } deb_status_t;

    localparam logic [1:0] MODE_HALT = 2'd0;
    localparam logic [1:0] MODE_FWD  = 2'd1;
    localparam logic [1:0] MODE_REV  = 2'd2;

    localparam logic [7:0] ELAPSED_MAX   = 8'd255;
    localparam logic [7:0] DEBOUNCE_RST  = 8'd30;
    localparam logic [7:0] STEP_PER_RST  = 8'd3;

    localparam logic [7:0] CFG_IDX_DEBOUNCE = 8'd0;
    localparam logic [7:0] CFG_IDX_STEP_PER = 8'd1;

    // Full-step pattern, two coils on; bit 0 drives the first coil.
    function automatic logic [3:0] coil_lookup(input logic [1:0] phase);
        logic [3:0] pat;
        case (phase)
            2'd0:    pat = 4'h9;
            2'd1:    pat = 4'h3;
            2'd2:    pat = 4'h6;
            2'd3:    pat = 4'hC;
            default: pat = 4'h0;
        endcase
        return pat;
    endfunction

endpackage

// ----- rtl/core/bts_debounce.sv -----
// Debouncer for one push button, advanced once per tick.
// Depends on bts_pkg for the status struct and the counter limit.
module bts_debounce (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               tick,
    input  logic               raw,
    input  logic [7:0]         hold_limit,
    output bts_pkg::deb_status_t status
);

    logic       prev_reg, prev_next;
    logic       stable_reg, stable_next;
    logic [7:0] elapsed_reg, elapsed_next;
    logic       take;

    always_comb
    begin
        prev_next = raw;
        if (raw != prev_reg)
        begin
            elapsed_next = 8'd0;
        end
        else if (elapsed_reg != bts_pkg::ELAPSED_MAX)
        begin
            elapsed_next = elapsed_reg + 8'd1;
        end
        else
        begin
            elapsed_next = elapsed_reg;
        end
        // A level is taken once it has been stable for more than the limit.
        take        = (elapsed_next > hold_limit) && (raw != stable_reg);
        stable_next = take ? raw : stable_reg;
        status.level = stable_next;
        status.rise  = take && raw;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg    <= 1'b0;
            stable_reg  <= 1'b0;
            elapsed_reg <= 8'd0;
        end
        else if (tick)
        begin
            prev_reg    <= prev_next;
            stable_reg  <= stable_next;
            elapsed_reg <= elapsed_next;
        end
    end

endmodule

// ----- rtl/core/button_toggled_stepper_sequencer.sv -----
// Top level of the button toggled stepper sequencer.
// Depends on bts_pkg and bts_debounce.

// Each request is one millisecond tick carrying the raw levels of the forward
// and reverse buttons, and each request yields exactly one result with the
// coil drive, the run mode, a step flag and both debounced button levels. The
// block sustains one request per clock cycle while results are taken: a request
// lands in an input register, and when that register advances a single pass of
// logic debounces both buttons, updates the mode, step timer and phase, and
// loads the result register. While a result waits for the consumer the input
// register can still take one more request, and both stages stall together only
// when both are full and the result is not being taken.
// The two configuration registers (debounce limit and step period) are written
// through a separate channel that is always ready; indexes beyond the two
// registers are accepted and ignored. Write them only while no request is in
// flight. A step period of zero behaves as one, and a debounce limit of 255
// freezes both debounced levels.
module button_toggled_stepper_sequencer (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  bts_pkg::in_item_t  in_data,
    output logic               out_valid,
    input  logic               out_ready,
    output bts_pkg::out_item_t out_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [7:0]         cfg_index,
    input  logic [7:0]         cfg_data
);

    // Configuration registers.
    logic [7:0] deb_limit_reg;
    logic [7:0] step_period_reg;

    // Input stage.
    logic               s1_valid_reg;
    bts_pkg::in_item_t  s1_data_reg;
    logic               s1_adv;

    // Sequencer state.
    logic [1:0] mode_reg, mode_next;
    logic [1:0] phase_reg, phase_next;
    logic [7:0] timer_reg, timer_next;

    // Result stage.
    logic               out_valid_reg;
    bts_pkg::out_item_t out_data_reg, out_data_next;

    bts_pkg::deb_status_t fwd_st;
    bts_pkg::deb_status_t rev_st;

    logic [1:0] mode_mid;
    logic [7:0] period;
    logic       stepped;

    // The input stage moves on whenever the result register is free or drained.
    assign s1_adv    = s1_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !s1_valid_reg || s1_adv;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            deb_limit_reg   <= bts_pkg::DEBOUNCE_RST;
            step_period_reg <= bts_pkg::STEP_PER_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                bts_pkg::CFG_IDX_DEBOUNCE: deb_limit_reg   <= cfg_data;
                bts_pkg::CFG_IDX_STEP_PER: step_period_reg <= cfg_data;
                default:                   deb_limit_reg   <= deb_limit_reg;
            endcase
        end
    end

    // Both debouncers advance only when a tick is processed.
    bts_debounce u_fwd_deb (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (s1_adv),
        .raw        (s1_data_reg.fwd_button_raw),
        .hold_limit (deb_limit_reg),
        .status     (fwd_st)
    );

    bts_debounce u_rev_deb (
        .clk        (clk),
        .rst_n      (rst_n),
        .tick       (s1_adv),
        .raw        (s1_data_reg.rev_button_raw),
        .hold_limit (deb_limit_reg),
        .status     (rev_st)
    );

    always_comb
    begin
        period = (step_period_reg == 8'd0) ? 8'd1 : step_period_reg;

        // The forward edge is applied first, so a reverse edge on the same tick wins.
        mode_mid = mode_reg;
        if (fwd_st.rise)
        begin
            mode_mid = (mode_reg == bts_pkg::MODE_FWD) ? bts_pkg::MODE_HALT
                                                       : bts_pkg::MODE_FWD;
        end
        mode_next = mode_mid;
        if (rev_st.rise)
        begin
            mode_next = (mode_mid == bts_pkg::MODE_REV) ? bts_pkg::MODE_HALT
                                                        : bts_pkg::MODE_REV;
        end

        stepped    = 1'b0;
        phase_next = phase_reg;
        timer_next = 8'd0;
        if ((mode_next == bts_pkg::MODE_FWD) || (mode_next == bts_pkg::MODE_REV))
        begin
            // Entering a running mode steps at once and restarts the timer.
            if ((mode_next != mode_reg) || (timer_reg == 8'd0))
            begin
                stepped    = 1'b1;
                timer_next = period - 8'd1;
                phase_next = (mode_next == bts_pkg::MODE_FWD) ? phase_reg + 2'd1
                                                              : phase_reg - 2'd1;
            end
            else
            begin
                timer_next = timer_reg - 8'd1;
            end
            out_data_next.coil_pattern = bts_pkg::coil_lookup(phase_next);
        end
        else
        begin
            mode_next                  = bts_pkg::MODE_HALT;
            out_data_next.coil_pattern = 4'h0;
        end

        out_data_next.motor_mode       = mode_next;
        out_data_next.step_taken       = stepped;
        out_data_next.fwd_button_level = fwd_st.level;
        out_data_next.rev_button_level = rev_st.level;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            mode_reg      <= bts_pkg::MODE_HALT;
            phase_reg     <= 2'd0;
            timer_reg     <= 8'd0;
        end
        else
        begin
            if (in_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s1_adv)
            begin
                out_valid_reg <= 1'b1;
                mode_reg      <= mode_next;
                phase_reg     <= phase_next;
                timer_reg     <= timer_next;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            s1_data_reg <= in_data;
        end
        if (s1_adv)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // A step is only ever reported while running.
    a_step_running: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.step_taken |->
            out_data_reg.motor_mode != bts_pkg::MODE_HALT)
        else $error("step reported while stopped");

    // Coils are dark exactly when the motor is stopped.
    a_coils_stop: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            ((out_data_reg.motor_mode == bts_pkg::MODE_HALT) ==
             (out_data_reg.coil_pattern == 4'h0)))
        else $error("coil pattern does not match mode");

    // A stalled input stage keeps its request.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_adv |=> s1_valid_reg)
        else $error("input stage dropped a request");

    // The phase only moves on a tick that reports a step.
    a_phase_step: assert property (@(posedge clk) disable iff (!rst_n)
        !s1_adv |=> $stable(phase_reg))
        else $error("phase changed without a tick");

endmodule
